// ----- hdl/spm_pkg.sv -----
`timescale 1ns / 1ps
package spm_pkg;

	// mapping register codes
	typedef enum logic [1:0] {
		MAP_LINEAR = 2'd0,
		MAP_FLOOR  = 2'd1,
		MAP_ROUND  = 2'd2,
		MAP_RSVD   = 2'd3
	} map_t;

	// configuration register indexes
	localparam logic REG_WINDOW  = 1'b0;
	localparam logic REG_MAPPING = 1'b1;

	localparam logic [15:0] WINDOW_RESET = 16'd10;

	// how the final remainder decides the pulse
	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_ONE  = 2'd1,
		CLS_EQ   = 2'd2,
		CLS_NE   = 2'd3
	} cls_t;

	typedef struct packed {
		cls_t cls;
		logic use_div;
	} ctl_t;

endpackage

// ----- hdl/spm_front.sv -----
`timescale 1ns / 1ps
module spm_front #(
	parameter int N = 16
) (
	input  logic [N-1:0]   window,
	input  spm_pkg::map_t  mapping,
	input  logic [N-1:0]   s,
	input  logic [N-1:0]   x,
	output spm_pkg::ctl_t  ctl,
	output logic [N-1:0]   ddirect,
	output logic [N+1:0]   num1,
	output logic [N+1:0]   den1
);
	import spm_pkg::*;

	logic [N-1:0] top;
	logic [N-1:0] half;
	logic [N-1:0] cden;

	assign top  = window - N'(1);
	assign half = window >> 1;
	assign cden = top - x;

	// classify the item and set up the first division
	always_comb begin
		ctl.cls     = CLS_ZERO;
		ctl.use_div = 1'b0;
		ddirect     = N'(1);
		num1        = (N+2)'(1);
		den1        = (N+2)'(1);
		if (x < window) begin
			case (mapping)
				MAP_LINEAR: begin
					ctl.cls = CLS_EQ;
					ddirect = window - x;
				end
				MAP_FLOOR: begin
					if (x < half) begin
						if (s == '0) begin
							ctl.cls = CLS_ONE;
						end else if (x == '0) begin
							ctl.cls = CLS_ZERO;
						end else begin
							ctl.cls     = CLS_EQ;
							ctl.use_div = 1'b1;
							num1        = {2'b00, top};
							den1        = {2'b00, x};
						end
					end else if (x >= top) begin
						ctl.cls = CLS_ONE;
					end else begin
						ctl.cls     = CLS_NE;
						ctl.use_div = 1'b1;
						num1        = {2'b00, top};
						den1        = {2'b00, cden};
					end
				end
				MAP_ROUND: begin
					if ({x, 1'b0} < {1'b0, window}) begin
						if (s == '0) begin
							ctl.cls = CLS_ONE;
						end else if (x == '0) begin
							ctl.cls = CLS_ZERO;
						end else begin
							ctl.cls     = CLS_EQ;
							ctl.use_div = 1'b1;
							num1        = {1'b0, top, 1'b0} + {2'b00, x};
							den1        = {1'b0, x, 1'b0};
						end
					end else if (x >= top) begin
						ctl.cls = CLS_ONE;
					end else begin
						ctl.cls     = CLS_NE;
						ctl.use_div = 1'b1;
						num1        = {1'b0, top, 1'b0} + {2'b00, cden};
						den1        = {1'b0, cden, 1'b0};
					end
				end
				default: begin
					ctl.cls = CLS_ZERO;
				end
			endcase
		end
	end

endmodule

// ----- hdl/spm_queue.sv -----
`timescale 1ns / 1ps
module spm_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  logic [DW-1:0] wdata,
	input  logic          rd,
	output logic [DW-1:0] rdata,
	output logic          empty,
	output logic          full
);
	localparam int DEPTH = 4;

	logic [DW-1:0] mem_q [DEPTH];
	logic [1:0]    wptr_q;
	logic [1:0]    rptr_q;
	logic [2:0]    count_q;
	logic [2:0]    count_nxt;
	logic          full_q;
	logic          do_wr;
	logic          do_rd;

	assign do_wr = wr && !full_q;
	assign do_rd = rd && (count_q != 3'd0);
	assign empty = (count_q == 3'd0);
	assign full  = full_q;
	assign rdata = mem_q[rptr_q];

	always_comb begin
		count_nxt = count_q + {2'b00, do_wr} - {2'b00, do_rd};
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
			full_q  <= 1'b0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + 2'd1;
			if (do_rd) rptr_q <= rptr_q + 2'd1;
			count_q <= count_nxt;
			full_q  <= (count_nxt == 3'(DEPTH));
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wdata;
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(DEPTH)) else $error("queue over depth");
	a_full_match: assert property (@(posedge clk) disable iff (!arst_n)
		full_q == (count_q == 3'(DEPTH))) else $error("full flag out of step");
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!rd && !wr |=> count_q == $past(count_q)) else $error("level moved when idle");
`endif

endmodule

// ----- hdl/spm_div.sv -----
`timescale 1ns / 1ps
module spm_div #(
	parameter int W  = 18,
	parameter int SW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	input  logic [SW-1:0] side,
	output logic          out_vld,
	output logic [W-1:0]  quot,
	output logic [W-1:0]  rem,
	output logic [SW-1:0] side_out
);
	logic          vld_q  [W];
	logic [W-1:0]  rem_q  [W];
	logic [W-1:0]  num_q  [W];
	logic [W-1:0]  den_q  [W];
	logic [W-1:0]  quo_q  [W];
	logic [SW-1:0] side_q [W];

	// one quotient bit per stage, restoring
	for (genvar k = 0; k < W; k++) begin : g_stage
		logic          v_in;
		logic [W-1:0]  r_in;
		logic [W-1:0]  n_in;
		logic [W-1:0]  d_in;
		logic [W-1:0]  q_in;
		logic [SW-1:0] s_in;
		logic [W:0]    trial;
		logic [W:0]    diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in = in_vld;
			assign r_in = '0;
			assign n_in = num;
			assign d_in = den;
			assign q_in = '0;
			assign s_in = side;
		end else begin : g_next
			assign v_in = vld_q[k-1];
			assign r_in = rem_q[k-1];
			assign n_in = num_q[k-1];
			assign d_in = den_q[k-1];
			assign q_in = quo_q[k-1];
			assign s_in = side_q[k-1];
		end

		assign trial = {r_in, n_in[W-1]};
		assign diff  = trial - {1'b0, d_in};
		assign ge    = (trial >= {1'b0, d_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? diff[W-1:0] : trial[W-1:0];
				num_q[k]  <= n_in << 1;
				den_q[k]  <= d_in;
				quo_q[k]  <= {q_in[W-2:0], ge};
				side_q[k] <= s_in;
			end
		end
	end

	assign out_vld  = vld_q[W-1];
	assign quot     = quo_q[W-1];
	assign rem      = rem_q[W-1];
	assign side_out = side_q[W-1];

endmodule

// ----- hdl/spike_rate_pulse_mapper_unit.sv -----
`timescale 1ns / 1ps
// Spike rate pulse mapper: for each (step, level) transfer one pulse bit comes
// out, in order, at a sustained rate of one item per clock while out_stall is
// low. The item is classified and written to a four-entry queue, then passes a
// STEP_BITS+2 stage pipelined divider that forms the modulus, a STEP_BITS stage
// divider that forms the step remainder, and an output register. window_length
// and mapping go through the cfg port; the user must write them only while the
// block is idle, which the block itself does not enforce.
module spike_rate_pulse_mapper_unit #(
	parameter int STEP_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] step,
	input  logic [15:0] level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pulse
);
	import spm_pkg::*;

	localparam int N   = STEP_BITS;
	localparam int CW  = $bits(ctl_t);
	localparam int QW  = CW + N + N + (N + 2) + (N + 2);
	localparam int S1W = CW + N + N;

	logic [15:0]  window_q;
	map_t         mapping_q;
	logic [N-1:0] s_in;
	logic [N-1:0] x_in;
	ctl_t         f_ctl;
	logic [N-1:0] f_ddirect;
	logic [N+1:0] f_num1;
	logic [N+1:0] f_den1;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;
	logic         q_empty;
	logic         q_full;
	logic         adv;
	logic         pop;
	ctl_t         b_ctl;
	logic [N-1:0] b_s;
	logic [N-1:0] b_ddirect;
	logic [N+1:0] b_num1;
	logic [N+1:0] b_den1;
	logic         d1_vld;
	logic [N+1:0] d1_quot;
	logic [N+1:0] d1_rem;
	logic [S1W-1:0] d1_side;
	ctl_t         m_ctl;
	logic [N-1:0] m_s;
	logic [N-1:0] m_ddirect;
	logic [N-1:0] m_den;
	logic         d2_vld;
	logic [N-1:0] d2_quot;
	logic [N-1:0] d2_rem;
	logic [CW-1:0] d2_side;
	ctl_t         o_ctl;
	logic         fire;
	logic         out_vld_q;
	logic         pulse_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RESET;
			mapping_q <= MAP_LINEAR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW:  window_q  <= cfg_data;
				REG_MAPPING: mapping_q <= map_t'(cfg_data[1:0]);
				default:     ;
			endcase
		end
	end

	assign s_in = N'(step);
	assign x_in = N'(level);

	spm_front #(.N(N)) u_front (
		.window  (N'(window_q)),
		.mapping (mapping_q),
		.s       (s_in),
		.x       (x_in),
		.ctl     (f_ctl),
		.ddirect (f_ddirect),
		.num1    (f_num1),
		.den1    (f_den1)
	);

	assign q_wdata  = {f_ctl, s_in, f_ddirect, f_num1, f_den1};
	assign in_stall = q_full;

	// back end advances whenever the output register is free or taken
	assign adv = !out_vld_q || !out_stall;
	assign pop = adv && !q_empty;

	spm_queue #(.DW(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (in_valid),
		.wdata  (q_wdata),
		.rd     (pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign {b_ctl, b_s, b_ddirect, b_num1, b_den1} = q_rdata;

	// modulus from the window and level
	spm_div #(.W(N + 2), .SW(S1W)) u_div_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (pop),
		.num      (b_num1),
		.den      (b_den1),
		.side     ({b_ctl, b_s, b_ddirect}),
		.out_vld  (d1_vld),
		.quot     (d1_quot),
		.rem      (d1_rem),
		.side_out (d1_side)
	);

	assign {m_ctl, m_s, m_ddirect} = d1_side;
	assign m_den = m_ctl.use_div ? d1_quot[N-1:0] : m_ddirect;

	// step remainder
	spm_div #(.W(N), .SW(CW)) u_div_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (d1_vld),
		.num      (m_s),
		.den      (m_den),
		.side     (m_ctl),
		.out_vld  (d2_vld),
		.quot     (d2_quot),
		.rem      (d2_rem),
		.side_out (d2_side)
	);

	assign o_ctl = ctl_t'(d2_side);

	// pulse decision
	always_comb begin
		case (o_ctl.cls)
			CLS_ONE: fire = 1'b1;
			CLS_EQ:  fire = (d2_rem == '0);
			CLS_NE:  fire = (d2_rem != '0);
			default: fire = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) pulse_q <= fire;
	end

	assign out_valid = out_vld_q;
	assign pulse     = pulse_q;

`ifndef SYNTHESIS
	a_no_pop_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_stall |-> !pop) else $error("queue read while output stalled");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_stall |=> out_vld_q && $stable(pulse_q))
		else $error("output changed while stalled");
	a_pipe_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(d2_vld)) else $error("back end moved while stalled");
`endif

endmodule

// ----- tb/spike_rate_pulse_mapper_unit_tb.sv -----
`timescale 1ns / 1ps
module spike_rate_pulse_mapper_unit_tb;
	import spm_pkg::*;

	localparam int LATENCY  = 2 * 16 + 3;
	localparam int WD_LIMIT = 20000;
	localparam int N_RANDOM = 1830;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] step;
	logic [15:0] level;
	logic        out_valid;
	logic        out_stall;
	logic        pulse;

	spike_rate_pulse_mapper_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.step(step), .level(level), .out_valid(out_valid),
		.out_stall(out_stall), .pulse(pulse)
	);

	// local copy of the block's registers
	logic [15:0] window_q;
	map_t        map_q;

	// expected pulses in transfer order
	logic pulse_fifo[$];
	int   mismatches;
	int   pulses_seen;
	int   ones_seen;
	int   idle_cycles;
	bit   done_sending;
	bit   hold_off;

	// directed stimulus; chk says the expected pulse is typed in
	typedef struct {
		logic [15:0] w;
		map_t        m;
		logic [15:0] s;
		logic [15:0] x;
		bit          chk;
		logic        p;
	} row_t;

	row_t rows[$];

	always #4 clk = ~clk;

	function automatic logic [15:0] round_div(input logic [31:0] num, input logic [31:0] den);
		return 16'((2 * num + den) / (2 * den));
	endfunction

	// pulse decision for one (step, level) pair under the current registers
	function automatic logic spike_at(input logic [15:0] s, input logic [15:0] x);
		logic [31:0] w, top, q;
		w = window_q;
		top = w - 1;
		if (32'(x) >= w) return 1'b0;
		case (map_q)
			MAP_LINEAR: return (s % (w - x)) == 0;
			MAP_FLOOR: begin
				if (x < w / 2) begin
					if (s == 0) return 1'b1;
					if (x == 0) return 1'b0;
					q = top / x;
					return (s % q) == 0;
				end
				if (x >= top) return 1'b1;
				q = top / (top - x);
				return (s % q) != 0;
			end
			MAP_ROUND: begin
				if (2 * 32'(x) < w) begin
					if (s == 0) return 1'b1;
					if (x == 0) return 1'b0;
					q = round_div(top, x);
					return (s % q) == 0;
				end
				if (x >= top) return 1'b1;
				q = round_div(top, top - x);
				return (s % q) != 0;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WINDOW) window_q = val;
		else map_q = map_t'(val[1:0]);
	endtask

	// wait for the block to drain before touching registers
	task automatic wait_idle;
		while (pulse_fifo.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic set_config(input logic [15:0] w, input map_t m);
		if (w == window_q && m == map_q) return;
		wait_idle();
		write_reg(REG_WINDOW, w);
		write_reg(REG_MAPPING, 16'(m));
	endtask

	// offer one item with a given expected pulse and hold it until the transfer
	task automatic send_checked(input logic [15:0] s, input logic [15:0] x, input int gap,
			input logic exp_p);
		repeat (gap) @(negedge clk);
		in_valid = 1'b1;
		step     = s;
		level    = x;
		pulse_fifo.push_back(exp_p);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// offer one item checked against the predictor
	task automatic send_item(input logic [15:0] s, input logic [15:0] x, input int gap);
		send_checked(s, x, gap, spike_at(s, x));
	endtask

	function automatic logic [15:0] pick_window;
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 3));
			3, 4: return 16'($urandom);
			default: return 16'($urandom_range(2, 64));
		endcase
	endfunction

	function automatic logic [15:0] pick_level(input logic [15:0] w);
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return (w == 0) ? 16'd0 : w - 1;
			2: return w;
			3: return 16'd0;
			4: return (w < 2) ? 16'd0 : w - 2;
			default: return (w == 0) ? 16'd0 : 16'($urandom_range(0, w - 1));
		endcase
	endfunction

	function automatic logic [15:0] pick_step;
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(0, 200));
		endcase
	endfunction

	// receiver: random stall, with one long hold-off
	initial begin
		int n_wait;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
				out_stall <= 1'b0;
			end else begin
				n_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
				if (n_wait != 0) begin
					out_stall <= 1'b1;
					repeat (n_wait) @(negedge clk);
				end
				out_stall <= 1'b0;
			end
		end
	end

	// compare every output transfer against the oldest expectation
	always @(posedge clk) begin
		logic exp_p;
		if (arst_n && out_valid && !out_stall) begin
			pulses_seen++;
			ones_seen += pulse;
			if (pulse_fifo.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected pulse transfer: %b", pulse);
			end else begin
				exp_p = pulse_fifo.pop_front();
				if (pulse !== exp_p) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pulse mismatch: expected %b got %b", exp_p, pulse);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("watchdog expired");
			$display("** spike_rate_pulse_mapper_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		int gap, burst;
		clk = 1'b0; arst_n = 1'b0; cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
		in_valid = 1'b0; step = '0; level = '0;
		mismatches = 0; pulses_seen = 0; ones_seen = 0; idle_cycles = 0;
		done_sending = 1'b0; hold_off = 1'b0;
		window_q = WINDOW_RESET; map_q = MAP_LINEAR;

		// reset values, all mappings, zero window, reserved mapping, level at or over the window
		rows.push_back('{16'd10, MAP_LINEAR, 16'd0, 16'd0, 1, 1'b1});
		rows.push_back('{16'd10, MAP_LINEAR, 16'd5, 16'd5, 1, 1'b1});
		rows.push_back('{16'd10, MAP_LINEAR, 16'd3, 16'd10, 1, 1'b0});
		rows.push_back('{16'd10, MAP_LINEAR, 16'd0, 16'hFFFF, 1, 1'b0});
		rows.push_back('{16'd10, MAP_LINEAR, 16'hFFFF, 16'd9, 1, 1'b1});
		rows.push_back('{16'd10, MAP_LINEAR, 16'd7, 16'd3, 0, 1'b0});
		rows.push_back('{16'd10, MAP_FLOOR, 16'd0, 16'd0, 1, 1'b1});
		rows.push_back('{16'd10, MAP_FLOOR, 16'd5, 16'd0, 1, 1'b0});
		rows.push_back('{16'd10, MAP_FLOOR, 16'd6, 16'd2, 0, 1'b0});
		rows.push_back('{16'd10, MAP_FLOOR, 16'd7, 16'd9, 1, 1'b1});
		rows.push_back('{16'd10, MAP_FLOOR, 16'd4, 16'd6, 0, 1'b0});
		rows.push_back('{16'd10, MAP_ROUND, 16'd0, 16'd1, 1, 1'b1});
		rows.push_back('{16'd10, MAP_ROUND, 16'd9, 16'd0, 1, 1'b0});
		rows.push_back('{16'd10, MAP_ROUND, 16'd5, 16'd4, 0, 1'b0});
		rows.push_back('{16'd10, MAP_ROUND, 16'd3, 16'd7, 0, 1'b0});
		rows.push_back('{16'd10, MAP_ROUND, 16'd1, 16'd9, 1, 1'b1});
		rows.push_back('{16'd10, MAP_RSVD, 16'd0, 16'd0, 1, 1'b0});
		rows.push_back('{16'd0, MAP_LINEAR, 16'd0, 16'd0, 1, 1'b0});
		rows.push_back('{16'd0, MAP_FLOOR, 16'hFFFF, 16'hFFFF, 1, 1'b0});
		rows.push_back('{16'd1, MAP_LINEAR, 16'hFFFF, 16'd0, 1, 1'b1});
		rows.push_back('{16'hFFFF, MAP_LINEAR, 16'hFFFE, 16'd0, 1, 1'b0});
		rows.push_back('{16'hFFFF, MAP_FLOOR, 16'hFFFF, 16'hFFFE, 1, 1'b1});
		rows.push_back('{16'hFFFF, MAP_ROUND, 16'h1234, 16'h7FFF, 0, 1'b0});
		rows.push_back('{16'hFFFF, MAP_FLOOR, 16'hAAAA, 16'h5555, 0, 1'b0});

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (rows[i]) begin
			set_config(rows[i].w, rows[i].m);
			if (rows[i].chk && spike_at(rows[i].s, rows[i].x) !== rows[i].p)
				$display("table row %0d disagrees with predictor", i);
			if (rows[i].chk)
				send_checked(rows[i].s, rows[i].x, $urandom_range(0, 2), rows[i].p);
			else
				send_item(rows[i].s, rows[i].x, $urandom_range(0, 2));
		end

		// long receiver hold-off while items keep coming back to back
		wait_idle();
		hold_off = 1'b1;
		repeat (40) send_item(pick_step(), pick_level(window_q), 0);

		// random phases, each with its own register setting
		for (int n = 0; n < N_RANDOM; ) begin
			set_config(pick_window(), map_t'($urandom_range(0, 3)));
			burst = $urandom_range(20, 120);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
				send_item(pick_step(), pick_level(window_q), gap);
			end
		end
		done_sending = 1'b1;

		wait_idle();
		$display("checked %0d pulse transfers (%0d spikes) over all mappings and window extremes",
			pulses_seen, ones_seen);
		if (mismatches == 0 && pulse_fifo.size() == 0) begin
			$display("** spike_rate_pulse_mapper_unit: PASSED **");
		end else begin
			$display("%0d mismatches, %0d pulses missing", mismatches, pulse_fifo.size());
			$display("** spike_rate_pulse_mapper_unit: FAILED **");
		end
		$finish;
	end

endmodule
